// ----- src/adt_pkg.sv -----
// Shared types, constants and calendar helpers for the add-days-to-date block.
package adt_pkg;

    // Field widths of one item
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int YEAR_W   = 14;
    localparam int COUNT_W  = 16;
    localparam int S_DATA_W = 40;   // 39 bits of fields, padded to whole bytes
    localparam int M_DATA_W = 24;

    // Default width of the internal day counter
    localparam int COUNT_BITS_DEF = 16;

    // Calendar constants
    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
    localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [8:0]         YEAR_DAYS = 9'd365;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_MONTHS,
        ST_YEARS,
        ST_DONE
    } state_t;

    // One finished result, handed from the sequencer to the output register
    typedef struct packed {
        logic               overflow;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } result_t;

    // Days in a month; leap Februaries have 29 days (every year divisible by four)
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (month)
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            MONTH_APR,
            MONTH_JUN,
            MONTH_SEP,
            MONTH_NOV: len = 5'd30;
            default:   len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- src/adt_sub.sv -----
// Shared subtract-and-compare unit: remaining day count minus a span of days.
module adt_sub #(
    parameter int COUNT_BITS = adt_pkg::COUNT_BITS_DEF
) (
    input  logic [COUNT_BITS-1:0] left,
    input  logic [8:0]            span,
    output logic [COUNT_BITS-1:0] diff,
    output logic                  borrow
);

    logic [COUNT_BITS:0] wide_diff;

    // Borrow set means the count is shorter than the span
    assign wide_diff = {1'b0, left} - (COUNT_BITS+1)'(span);
    assign diff      = wide_diff[COUNT_BITS-1:0];
    assign borrow    = wide_diff[COUNT_BITS];

endmodule

// ----- src/adt_ctrl.sv -----
// Sequencer and date registers: normalizes the start date, then walks months and years.
module adt_ctrl #(
    parameter int COUNT_BITS = adt_pkg::COUNT_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [adt_pkg::DAY_W-1:0]    in_day,
    input  logic [adt_pkg::MONTH_W-1:0]  in_month,
    input  logic [adt_pkg::YEAR_W-1:0]   in_year,
    input  logic [adt_pkg::COUNT_W-1:0]  in_count,
    input  logic                         out_free,
    output logic                         ready,
    output logic                         done_valid,
    output adt_pkg::result_t             result
);

    // Year register must hold the start year plus every whole year the count can span
    localparam int YW_EXT = ((COUNT_BITS - 8) > adt_pkg::YEAR_W) ?
                            (COUNT_BITS - 8) : adt_pkg::YEAR_W;
    localparam int YR_W   = YW_EXT + 1;

    adt_pkg::state_t state_reg, state_next;

    logic [adt_pkg::DAY_W-1:0]   day_reg, day_next;
    logic [adt_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [YR_W-1:0]             year_reg, year_next;
    logic [COUNT_BITS-1:0]       left_reg, left_next;

    // Normalized start date
    logic [adt_pkg::DAY_W-1:0]   norm_day;
    logic [adt_pkg::MONTH_W-1:0] norm_month;
    logic [YR_W-1:0]             norm_year;

    // Shared unit operands
    logic [adt_pkg::DAY_W-1:0] cur_len;
    logic [8:0]                span;
    logic [COUNT_BITS-1:0]     diff;
    logic                      borrow;
    logic                      leap;

    assign leap    = (year_reg[1:0] == 2'b00);
    assign cur_len = adt_pkg::month_len(month_reg, leap);

    // Span is a whole year in year mode, else the days left in this month
    always_comb begin
        if (state_reg == adt_pkg::ST_YEARS) begin
            span = adt_pkg::YEAR_DAYS + 9'(leap);
        end else begin
            span = 9'(6'(cur_len) + 6'd1 - 6'(day_reg));
        end
    end

    adt_sub #(
        .COUNT_BITS(COUNT_BITS)
    ) u_sub (
        .left  (left_reg),
        .span  (span),
        .diff  (diff),
        .borrow(borrow)
    );

    // Start date clean-up: zero fields, month past December, day past month end
    always_comb begin
        logic [adt_pkg::DAY_W-1:0]   d;
        logic [adt_pkg::MONTH_W-1:0] m;
        logic [YR_W-1:0]             y;
        d = day_reg;
        m = month_reg;
        y = year_reg;
        if (m == '0) begin
            m = adt_pkg::MONTH_JAN;
        end
        if (m > adt_pkg::MONTH_DEC) begin
            d = adt_pkg::DAY_FIRST;
            m = adt_pkg::MONTH_JAN;
            y = y + 1'b1;
        end
        if (d == '0) begin
            d = adt_pkg::DAY_FIRST;
        end
        if (d > adt_pkg::month_len(m, y[1:0] == 2'b00)) begin
            d = adt_pkg::DAY_FIRST;
            if (m == adt_pkg::MONTH_DEC) begin
                m = adt_pkg::MONTH_JAN;
                y = y + 1'b1;
            end else begin
                m = m + 1'b1;
            end
        end
        norm_day   = d;
        norm_month = m;
        norm_year  = y;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            adt_pkg::ST_IDLE: begin
                if (start) state_next = adt_pkg::ST_NORM;
            end
            adt_pkg::ST_NORM: begin
                if (norm_day == adt_pkg::DAY_FIRST && norm_month == adt_pkg::MONTH_JAN) begin
                    state_next = adt_pkg::ST_YEARS;
                end else begin
                    state_next = adt_pkg::ST_MONTHS;
                end
            end
            adt_pkg::ST_MONTHS: begin
                if (borrow) begin
                    state_next = adt_pkg::ST_DONE;
                end else if (month_reg == adt_pkg::MONTH_DEC) begin
                    state_next = adt_pkg::ST_YEARS;
                end
            end
            adt_pkg::ST_YEARS: begin
                if (borrow) state_next = adt_pkg::ST_MONTHS;
            end
            adt_pkg::ST_DONE: begin
                if (out_free) state_next = adt_pkg::ST_IDLE;
            end
            default: state_next = adt_pkg::ST_IDLE;
        endcase
    end

    // Datapath updates
    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        left_next  = left_reg;
        case (state_reg)
            adt_pkg::ST_IDLE: begin
                if (start) begin
                    day_next   = in_day;
                    month_next = in_month;
                    year_next  = YR_W'(in_year);
                    left_next  = COUNT_BITS'(in_count);
                end
            end
            adt_pkg::ST_NORM: begin
                day_next   = norm_day;
                month_next = norm_month;
                year_next  = norm_year;
            end
            adt_pkg::ST_MONTHS: begin
                if (borrow) begin
                    // count fits in this month: it is below 31 here
                    day_next = day_reg + left_reg[adt_pkg::DAY_W-1:0];
                end else begin
                    left_next = diff;
                    day_next  = adt_pkg::DAY_FIRST;
                    if (month_reg == adt_pkg::MONTH_DEC) begin
                        month_next = adt_pkg::MONTH_JAN;
                        year_next  = year_reg + 1'b1;
                    end else begin
                        month_next = month_reg + 1'b1;
                    end
                end
            end
            adt_pkg::ST_YEARS: begin
                if (!borrow) begin
                    left_next = diff;
                    year_next = year_reg + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= adt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        left_reg  <= left_next;
    end

    // Handshake outputs and clamped result
    always_comb begin
        ready           = (state_reg == adt_pkg::ST_IDLE);
        done_valid      = (state_reg == adt_pkg::ST_DONE);
        result.day      = day_reg;
        result.month    = month_reg;
        result.overflow = (year_reg > YR_W'(adt_pkg::YEAR_MAX));
        result.year     = result.overflow ? adt_pkg::YEAR_MAX
                                          : year_reg[adt_pkg::YEAR_W-1:0];
    end

endmodule

// ----- src/add_days_to_date.sv -----
// Top level: stream ports, sequencer and output register of the add-days-to-date block.
//
// Adds a day count to a calendar date (February has 29 days in every year divisible
// by four) and returns the resulting date; years past 9999 clamp to 9999 with
// year_overflow set. One item at a time, all on one shared subtractor: once an item
// is taken, the sequencer normalizes the start date, then steps one month or skips
// one whole year at a time, testing for a whole year when the walk reaches 1 January.
// The walk steps months up to the next 1 January, skips whole years, then steps the
// last months, and the next item can be taken once the result has moved into the
// output register. The result sits in that register, so the next item is taken while
// the last result waits; s_tready is low while an item is being worked on.
module add_days_to_date #(
    parameter int COUNT_BITS = adt_pkg::COUNT_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // start_day[4:0], start_month[8:5], start_year[22:9], day_count[38:23], pad[39]
    input  logic [adt_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // result_day[4:0], result_month[8:5], result_year[22:9], year_overflow[23]
    output logic [adt_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);

    logic             ready;
    logic             done_valid;
    logic             out_free;
    logic             m_tvalid_reg, m_tvalid_next;
    adt_pkg::result_t m_data_reg;
    adt_pkg::result_t result;

    adt_ctrl #(
        .COUNT_BITS(COUNT_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && ready),
        .in_day    (s_tdata[4:0]),
        .in_month  (s_tdata[8:5]),
        .in_year   (s_tdata[22:9]),
        .in_count  (s_tdata[38:23]),
        .out_free  (out_free),
        .ready     (ready),
        .done_valid(done_valid),
        .result    (result)
    );

    // Output register takes a result once the previous one has gone
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (done_valid && out_free) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (done_valid && out_free) begin
            m_data_reg <= result;
        end
    end

    assign s_tready = ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- src/adt_checker.sv -----
// Port-level checker for the add-days-to-date block, bound to its top level.
module adt_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [adt_pkg::M_DATA_W-1:0]  m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    // A held result stays put until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: no second item right after one is taken
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // Result month is a real month
    a_month: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8:5] >= adt_pkg::MONTH_JAN && m_tdata[8:5] <= adt_pkg::MONTH_DEC)
        else $error("result month out of range");

    // Result day is never zero
    a_day: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[4:0] != 5'd0)
        else $error("result day is zero");

    // Overflow always comes with the clamped year
    a_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23] |-> m_tdata[22:9] == adt_pkg::YEAR_MAX)
        else $error("overflow without clamped year");

endmodule

bind add_days_to_date adt_checker u_adt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready)
);
